@@ rtl/core/text_console_writer_macros.svh @@
// ---------------------------------------------------------------------------
// text console writer assertion macros
// shared helpers for the concurrent checks of the console engine
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// check that is switched off while reset is high
`define TCW_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("%m: check failed");

// check that also holds through reset
`define TCW_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: check failed");

`endif

@@ rtl/core/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// types, constants and helpers shared by the text console writer modules
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int WCNT_W = COL_W + 1;
  localparam int HCNT_W = ROW_W + 1;
  localparam int CNT_W  = ADDR_W + 1;

  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int CMD_W  = 2;

  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 7;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_ROWS    = 1'd1;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET  = 8'd80;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET  = 7'd25;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_WRITE,
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  ch;
    logic [CHAR_W-1:0]  attr;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic init_active;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_ADDR,
    S_EXEC,
    S_RDWAIT,
    S_SCRSET,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_POS,
    S_DONE
  } state_t;

  function automatic logic [WCNT_W-1:0] sat_cols(input logic [CFG_COLS_W-1:0] v);
    logic [WCNT_W-1:0] r;
    if (v == '0) r = WCNT_W'(1);
    else if (int'(v) > MAX_COLUMNS) r = WCNT_W'(MAX_COLUMNS);
    else r = WCNT_W'(v);
    return r;
  endfunction

  function automatic logic [HCNT_W-1:0] sat_rows(input logic [CFG_ROWS_W-1:0] v);
    logic [HCNT_W-1:0] r;
    if (v == '0) r = HCNT_W'(1);
    else if (int'(v) > MAX_ROWS) r = HCNT_W'(MAX_ROWS);
    else r = HCNT_W'(v);
    return r;
  endfunction

endpackage

@@ rtl/core/tcw_front.sv @@
// ---------------------------------------------------------------------------
// tcw_front
// takes command transactions and sorts them into engine operations
// ---------------------------------------------------------------------------
module tcw_front (
  input  logic                       start,
  input  logic [tcw_pkg::CMD_W-1:0]  cmd,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::CHAR_W-1:0] attribute,
  input  logic                       return_enabled,
  input  logic [tcw_pkg::ADDR_W-1:0] cell_address,
  input  tcw_pkg::q_stat_t           q_stat,
  input  tcw_pkg::back_stat_t        back_stat,
  output logic                       busy,
  output logic                       push,
  output tcw_pkg::entry_t            entry
);

  tcw_pkg::kind_t kind;

  always_comb begin
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (char_code == tcw_pkg::CODE_NEWLINE) begin
          kind = tcw_pkg::K_NEWLINE;
        end else if (char_code == tcw_pkg::CODE_RETURN && return_enabled) begin
          kind = tcw_pkg::K_RETURN;
        end else begin
          kind = tcw_pkg::K_WRITE;
        end
      end
      tcw_pkg::CMD_BACKSPACE: kind = tcw_pkg::K_BACKSPACE;
      tcw_pkg::CMD_CLEAR:     kind = tcw_pkg::K_CLEAR;
      default:                kind = tcw_pkg::K_READ;
    endcase
  end

  // no transactions while the buffer is being blanked after reset
  assign busy = q_stat.full || back_stat.init_active;
  assign push = start && !busy;

  assign entry.kind = kind;
  assign entry.ch   = char_code;
  assign entry.attr = attribute;
  assign entry.addr = cell_address;

endmodule

@@ rtl/core/tcw_queue.sv @@
// ---------------------------------------------------------------------------
// tcw_queue
// small fifo of sorted operations between the front and the engine
// ---------------------------------------------------------------------------
module tcw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcw_pkg::entry_t   wr_entry,
  input  logic              pop,
  output tcw_pkg::entry_t   head,
  output tcw_pkg::q_stat_t  q_stat
);

  tcw_pkg::entry_t                slots [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tcw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tcw_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == tcw_pkg::QCNT_W'(tcw_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

@@ rtl/core/tcw_back.sv @@
// ---------------------------------------------------------------------------
// tcw_back
// console engine: cell buffer, cursor, scroll and clear sweeps, results
// ---------------------------------------------------------------------------
module tcw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tcw_pkg::CFG_COLS_W-1:0] cols_cfg,
  input  logic [tcw_pkg::CFG_ROWS_W-1:0] rows_cfg,
  input  tcw_pkg::q_stat_t               q_stat,
  input  tcw_pkg::entry_t                head,
  output logic                           pop,
  output tcw_pkg::back_stat_t            back_stat,
  output logic                           done,
  output logic [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ADDR_W-1:0]     cursor_position,
  output logic                           scrolled
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  tcw_pkg::entry_t cur;

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::STORE_DEPTH];
  logic                       mem_we;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [tcw_pkg::ADDR_W-1:0] mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  logic [tcw_pkg::WCNT_W-1:0] w;
  logic [tcw_pkg::HCNT_W-1:0] h;
  logic [tcw_pkg::COL_W-1:0]  col;
  logic [tcw_pkg::ROW_W-1:0]  row;
  logic [tcw_pkg::ADDR_W-1:0] prod;
  logic [tcw_pkg::CNT_W-1:0]  cnt;
  logic [tcw_pkg::CNT_W-1:0]  moved;
  logic                       pend;
  logic [tcw_pkg::ADDR_W-1:0] pend_addr;
  logic [tcw_pkg::CELL_W-1:0] data_res;
  logic                       scr;

  logic [tcw_pkg::WCNT_W-1:0] col_p1;
  logic                       wrap;
  logic                       row_last;
  logic                       copy_left;

  assign w         = tcw_pkg::sat_cols(cols_cfg);
  assign h         = tcw_pkg::sat_rows(rows_cfg);
  assign col_p1    = {1'b0, col} + tcw_pkg::WCNT_W'(1);
  assign wrap      = (col_p1 >= w);
  assign row_last  = (({1'b0, row} + tcw_pkg::HCNT_W'(1)) >= h);
  assign copy_left = (cnt < moved);

  assign back_stat.init_active = (state == tcw_pkg::S_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = tcw_pkg::BLANK_CELL;
    mem_raddr  = '0;
    case (state)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::STORE_DEPTH - 1)) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = tcw_pkg::S_PREP;
        end
      end
      tcw_pkg::S_PREP: state_next = tcw_pkg::S_ADDR;
      tcw_pkg::S_ADDR: state_next = tcw_pkg::S_EXEC;
      tcw_pkg::S_EXEC: begin
        case (cur.kind)
          tcw_pkg::K_WRITE: begin
            mem_we     = 1'b1;
            mem_waddr  = prod + tcw_pkg::ADDR_W'(col);
            mem_wdata  = {cur.attr, cur.ch};
            state_next = (wrap && row_last) ? tcw_pkg::S_SCRSET : tcw_pkg::S_POS;
          end
          tcw_pkg::K_NEWLINE: begin
            state_next = row_last ? tcw_pkg::S_SCRSET : tcw_pkg::S_POS;
          end
          tcw_pkg::K_BACKSPACE: begin
            mem_we     = (col != '0);
            mem_waddr  = prod + tcw_pkg::ADDR_W'(col) - tcw_pkg::ADDR_W'(1);
            state_next = tcw_pkg::S_POS;
          end
          tcw_pkg::K_CLEAR: state_next = tcw_pkg::S_CLEAR;
          tcw_pkg::K_READ: begin
            mem_raddr  = cur.addr;
            state_next = tcw_pkg::S_RDWAIT;
          end
          default: state_next = tcw_pkg::S_POS;
        endcase
      end
      tcw_pkg::S_RDWAIT: state_next = tcw_pkg::S_POS;
      tcw_pkg::S_SCRSET: state_next = tcw_pkg::S_SCROLL;
      tcw_pkg::S_SCROLL: begin
        // read one row ahead, write the word read in the previous cycle
        if (copy_left) begin
          mem_raddr = cnt[tcw_pkg::ADDR_W-1:0] + tcw_pkg::ADDR_W'(w);
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end
        if (!copy_left && !pend) state_next = tcw_pkg::S_BLANK;
      end
      tcw_pkg::S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        if (cnt == moved + tcw_pkg::CNT_W'(w) - tcw_pkg::CNT_W'(1)) state_next = tcw_pkg::S_POS;
      end
      tcw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::STORE_DEPTH - 1)) state_next = tcw_pkg::S_POS;
      end
      tcw_pkg::S_POS:  state_next = tcw_pkg::S_DONE;
      tcw_pkg::S_DONE: state_next = tcw_pkg::S_IDLE;
      default:         state_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt             <= '0;
      done            <= 1'b0;
      row             <= '0;
      col             <= '0;
      pend            <= 1'b0;
      cell_data       <= '0;
      cursor_row      <= '0;
      cursor_col      <= '0;
      cursor_position <= '0;
      scrolled        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        tcw_pkg::S_INIT, tcw_pkg::S_CLEAR, tcw_pkg::S_BLANK: begin
          cnt <= cnt + tcw_pkg::CNT_W'(1);
        end
        tcw_pkg::S_IDLE: begin
          if (!q_stat.empty) begin
            cur      <= head;
            data_res <= '0;
            scr      <= 1'b0;
          end
        end
        tcw_pkg::S_PREP: begin
          // cursor may sit off screen after the screen shrank
          if ({1'b0, col} >= w) col <= tcw_pkg::COL_W'(w - tcw_pkg::WCNT_W'(1));
          if ({1'b0, row} >= h) row <= tcw_pkg::ROW_W'(h - tcw_pkg::HCNT_W'(1));
        end
        tcw_pkg::S_ADDR: begin
          prod <= tcw_pkg::ADDR_W'(row) * tcw_pkg::ADDR_W'(w);
        end
        tcw_pkg::S_EXEC: begin
          cnt  <= '0;
          pend <= 1'b0;
          case (cur.kind)
            tcw_pkg::K_WRITE: begin
              if (wrap) begin
                col <= '0;
                if (!row_last) row <= row + tcw_pkg::ROW_W'(1);
              end else begin
                col <= col_p1[tcw_pkg::COL_W-1:0];
              end
            end
            tcw_pkg::K_NEWLINE: begin
              col <= '0;
              if (!row_last) row <= row + tcw_pkg::ROW_W'(1);
            end
            tcw_pkg::K_RETURN: col <= '0;
            tcw_pkg::K_BACKSPACE: begin
              if (col != '0) col <= col - tcw_pkg::COL_W'(1);
            end
            tcw_pkg::K_CLEAR: begin
              row <= '0;
              col <= '0;
            end
            default: ;
          endcase
        end
        tcw_pkg::S_RDWAIT: data_res <= rd_data;
        tcw_pkg::S_SCRSET: begin
          moved <= tcw_pkg::CNT_W'(h - tcw_pkg::HCNT_W'(1)) * tcw_pkg::CNT_W'(w);
          scr   <= 1'b1;
        end
        tcw_pkg::S_SCROLL: begin
          if (copy_left) cnt <= cnt + tcw_pkg::CNT_W'(1);
          pend      <= copy_left;
          pend_addr <= cnt[tcw_pkg::ADDR_W-1:0];
        end
        tcw_pkg::S_POS: begin
          prod <= tcw_pkg::ADDR_W'(row) * tcw_pkg::ADDR_W'(w);
        end
        tcw_pkg::S_DONE: begin
          done            <= 1'b1;
          cell_data       <= data_res;
          cursor_row      <= row;
          cursor_col      <= col;
          cursor_position <= prod + tcw_pkg::ADDR_W'(col);
          scrolled        <= scr;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/text_console_writer.sv @@
// ---------------------------------------------------------------------------
// text_console_writer
// text-mode console engine with cell buffer, cursor, scroll and clear
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; its
// result appears later for one cycle with done high and must be taken then.
// A two-entry queue sits between the command front and the engine, so up to
// two commands may be waiting while one runs. In the engine a put, newline,
// carriage return or backspace runs the prep, address, execute, position
// and done states, and a read adds a read wait; the cursor sequencer does
// two row-times-width multiplies and the cell buffer has a single write
// port. A scroll moves the rows in use up one row, one cell per cycle, then
// blanks the last row; a clear blanks all of the buffer one cell per cycle.
// After reset busy stays high while the buffer is blanked; configuration
// writes are taken at any time and are meant for when the block is idle.
// ---------------------------------------------------------------------------
module text_console_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [tcw_pkg::CMD_W-1:0]      cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]     attribute,
  input  logic                           return_enabled,
  input  logic [tcw_pkg::ADDR_W-1:0]     cell_address,
  input  logic                           cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ADDR_W-1:0]     cursor_position,
  output logic                           scrolled
);

  logic [tcw_pkg::CFG_COLS_W-1:0] cols_cfg;
  logic [tcw_pkg::CFG_ROWS_W-1:0] rows_cfg;
  logic                           push;
  logic                           pop;
  tcw_pkg::entry_t                entry;
  tcw_pkg::entry_t                head;
  tcw_pkg::q_stat_t               q_stat;
  tcw_pkg::back_stat_t            back_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= tcw_pkg::COLS_RESET;
      rows_cfg <= tcw_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tcw_pkg::REG_COLUMNS: cols_cfg <= cfg_data[tcw_pkg::CFG_COLS_W-1:0];
        tcw_pkg::REG_ROWS:    rows_cfg <= cfg_data[tcw_pkg::CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .start          (start),
    .cmd            (cmd),
    .char_code      (char_code),
    .attribute      (attribute),
    .return_enabled (return_enabled),
    .cell_address   (cell_address),
    .q_stat         (q_stat),
    .back_stat      (back_stat),
    .busy           (busy),
    .push           (push),
    .entry          (entry)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  tcw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cols_cfg        (cols_cfg),
    .rows_cfg        (rows_cfg),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .back_stat       (back_stat),
    .done            (done),
    .cell_data       (cell_data),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .scrolled        (scrolled)
  );

endmodule

@@ rtl/core/tcw_checker.sv @@
// ---------------------------------------------------------------------------
// tcw_checker
// port-level checks on the text console writer, attached by bind
// ---------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       done,
  input logic [tcw_pkg::CELL_W-1:0] cell_data,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input logic [tcw_pkg::COL_W-1:0]  cursor_col,
  input logic [tcw_pkg::ADDR_W-1:0] cursor_position,
  input logic                       scrolled
);

  logic [tcw_pkg::CELL_W+tcw_pkg::ROW_W+tcw_pkg::COL_W+tcw_pkg::ADDR_W:0] result_word;

  assign result_word = {cell_data, cursor_row, cursor_col, cursor_position, scrolled};

  // buffer blanking keeps the block closed right after reset
  `TCW_ASSERT_ALWAYS(a_busy_after_reset, clk, rst |=> busy)

  // done comes only from the done state, which always returns to idle, so strobes never touch
  `TCW_ASSERT(a_done_single, clk, rst, done |=> !done)

  // result fields only move together with the strobe
  `TCW_ASSERT(a_result_hold, clk, rst, !done |-> $stable(result_word))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .busy            (busy),
  .done            (done),
  .cell_data       (cell_data),
  .cursor_row      (cursor_row),
  .cursor_col      (cursor_col),
  .cursor_position (cursor_position),
  .scrolled        (scrolled)
);
